// File: src/ipsp_pkg.sv
// Shared types, codes and constants for the IPS patch stream parser.
`timescale 1ns / 1ps
`default_nettype none
package ipsp_pkg;

   localparam int DATA_W   = 8;
   localparam int OFFSET_W = 24;
   localparam int SIZE_W   = 16;
   localparam int CFG_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int MAGIC_IDX_W = 3;
   localparam int MAGIC_LEN = 5;
   localparam int RSP_DATA_W = 56;

   localparam logic [OFFSET_W-1:0] EOF_MARK = 24'h454F46;

   localparam logic [CSR_IDX_W-1:0] CSR_ARM9_START    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM9_SIZE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM7_START    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM7_SIZE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAY_START = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM9_ONLY     = 3'd5;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_BAD   = 2'd3;

   localparam logic [1:0] REGION_NONE    = 2'd0;
   localparam logic [1:0] REGION_ARM9    = 2'd1;
   localparam logic [1:0] REGION_ARM7    = 2'd2;
   localparam logic [1:0] REGION_OVERLAY = 2'd3;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_OFF0,
      PH_OFF1,
      PH_OFF2,
      PH_SIZE0,
      PH_SIZE1,
      PH_RUN0,
      PH_RUN1,
      PH_RUNVAL,
      PH_DATA,
      PH_DONE,
      PH_BAD
   } phase_type;

   // Range ends are kept at one extra bit so they never wrap.
   typedef struct packed {
      logic [CFG_W-1:0] arm9_start;
      logic [CFG_W:0]   arm9_end;
      logic [CFG_W-1:0] arm7_start;
      logic [CFG_W:0]   arm7_end;
      logic [CFG_W-1:0] overlay_start;
      logic             arm9_only;
   } cfg_type;

   function automatic logic [DATA_W-1:0] magic_byte(input logic [MAGIC_IDX_W-1:0] idx);
      logic [DATA_W-1:0] value;
      case (idx)
         3'd0: value = 8'h50;
         3'd1: value = 8'h41;
         3'd2: value = 8'h54;
         3'd3: value = 8'h43;
         3'd4: value = 8'h48;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage
`default_nettype wire

// File: src/ipsp_csr.sv
// Configuration registers with precomputed arm9 and arm7 range ends.
`timescale 1ns / 1ps
`default_nettype none
module ipsp_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ipsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ipsp_pkg::CFG_W-1:0]           csr_data,
   output ipsp_pkg::cfg_type                         cfg
);

   logic [ipsp_pkg::CFG_W-1:0] arm9_start_ff, arm9_size_ff, arm7_start_ff, arm7_size_ff;
   logic [ipsp_pkg::CFG_W-1:0] overlay_start_ff;
   logic                       arm9_only_ff;
   logic [ipsp_pkg::CFG_W:0]   arm9_end_ff, arm7_end_ff;
   logic                       write;

   assign csr_ready = 1'b1;
   assign write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm9_start_ff    <= '0;
         arm9_size_ff     <= '0;
         arm7_start_ff    <= '0;
         arm7_size_ff     <= '0;
         overlay_start_ff <= '0;
         arm9_only_ff     <= 1'b0;
         arm9_end_ff      <= '0;
         arm7_end_ff      <= '0;
      end else if (write) begin
         case (csr_index)
            ipsp_pkg::CSR_ARM9_START: begin
               arm9_start_ff <= csr_data;
               arm9_end_ff   <= {1'b0, csr_data} + {1'b0, arm9_size_ff};
            end
            ipsp_pkg::CSR_ARM9_SIZE: begin
               arm9_size_ff <= csr_data;
               arm9_end_ff  <= {1'b0, arm9_start_ff} + {1'b0, csr_data};
            end
            ipsp_pkg::CSR_ARM7_START: begin
               arm7_start_ff <= csr_data;
               arm7_end_ff   <= {1'b0, csr_data} + {1'b0, arm7_size_ff};
            end
            ipsp_pkg::CSR_ARM7_SIZE: begin
               arm7_size_ff <= csr_data;
               arm7_end_ff  <= {1'b0, arm7_start_ff} + {1'b0, csr_data};
            end
            ipsp_pkg::CSR_OVERLAY_START: begin
               overlay_start_ff <= csr_data;
            end
            ipsp_pkg::CSR_ARM9_ONLY: begin
               arm9_only_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.arm9_start    = arm9_start_ff;
      cfg.arm9_end      = arm9_end_ff;
      cfg.arm7_start    = arm7_start_ff;
      cfg.arm7_end      = arm7_end_ff;
      cfg.overlay_start = overlay_start_ff;
      cfg.arm9_only     = arm9_only_ff;
   end

endmodule
`default_nettype wire

// File: src/ipsp_region.sv
// Region classification of a record offset and the arm9-to-arm7 gap test.
`timescale 1ns / 1ps
`default_nettype none
module ipsp_region (
   input  wire ipsp_pkg::cfg_type                cfg,
   input  wire logic [ipsp_pkg::OFFSET_W-1:0]    offset,
   output logic [1:0]                            region,
   output logic                                  in_gap
);

   localparam int EXT_W = ipsp_pkg::CFG_W + 1;

   logic [EXT_W-1:0] off_ext;
   logic             in_arm9, in_arm7, in_overlay;

   assign off_ext    = {{(EXT_W - ipsp_pkg::OFFSET_W){1'b0}}, offset};
   assign in_arm9    = (off_ext >= {1'b0, cfg.arm9_start}) && (off_ext < cfg.arm9_end);
   assign in_arm7    = (off_ext >= {1'b0, cfg.arm7_start}) && (off_ext < cfg.arm7_end);
   assign in_overlay = (off_ext >= {1'b0, cfg.overlay_start})
                       && (off_ext < {1'b0, cfg.arm7_start});
   assign in_gap     = (off_ext >= cfg.arm9_end) && (off_ext < {1'b0, cfg.arm7_start});

   always_comb begin
      if (cfg.arm9_only || in_arm9) begin
         region = ipsp_pkg::REGION_ARM9;
      end else if (in_arm7) begin
         region = ipsp_pkg::REGION_ARM7;
      end else if (in_overlay) begin
         region = ipsp_pkg::REGION_OVERLAY;
      end else begin
         region = ipsp_pkg::REGION_NONE;
      end
   end

endmodule
`default_nettype wire

// File: src/ipsp_parser.sv
// Input register, record parser state machine and result register.
`timescale 1ns / 1ps
`default_nettype none
module ipsp_parser (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ipsp_pkg::cfg_type                 cfg,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [ipsp_pkg::DATA_W-1:0]       in_byte,
   input  wire logic                              in_first,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [1:0]                             out_kind,
   output logic [ipsp_pkg::OFFSET_W-1:0]          out_offset,
   output logic [ipsp_pkg::SIZE_W-1:0]            out_length,
   output logic [ipsp_pkg::DATA_W-1:0]            out_value,
   output logic [1:0]                             out_region,
   output logic                                   out_overlay
);

   localparam int OFF_W  = ipsp_pkg::OFFSET_W;
   localparam int SIZE_W = ipsp_pkg::SIZE_W;
   localparam int DW     = ipsp_pkg::DATA_W;
   localparam int MW     = ipsp_pkg::MAGIC_IDX_W;

   // Input register.
   logic          in_valid_ff, in_valid_in;
   logic [DW-1:0] in_byte_ff;
   logic          in_first_ff;

   // Parser state.
   ipsp_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [MW-1:0]       magic_ff, magic_in, magic_cur;
   logic [OFF_W-1:0]    rec_off_ff, rec_off_in;
   logic [SIZE_W-1:0]   rec_size_ff, rec_size_in;
   logic [SIZE_W-1:0]   byte_idx_ff, byte_idx_in;
   logic [1:0]          rec_region_ff, rec_region_in;
   logic                ovl_ff, ovl_in, ovl_cur;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [SIZE_W-1:0] len_ff, len_in;
   logic [DW-1:0]     val_ff, val_in;
   logic [1:0]        region_ff, region_in;
   logic              ovl_out_ff, ovl_out_in;

   logic              advance, has_result;
   logic [OFF_W-1:0]  full_offset;
   logic [SIZE_W-1:0] idx_next;
   logic [1:0]        pick_region;
   logic              pick_gap;
   logic              magic_bad;

   assign advance  = in_valid_ff && (!rsp_valid_ff || out_ready);
   assign in_ready = !in_valid_ff || advance;

   // A first byte restarts the parser before it is looked at.
   assign phase_cur = in_first_ff ? ipsp_pkg::PH_MAGIC : phase_ff;
   assign magic_cur = in_first_ff ? '0 : magic_ff;
   assign ovl_cur   = in_first_ff ? 1'b0 : ovl_ff;

   assign full_offset = {rec_off_ff[OFF_W-1:DW], in_byte_ff};
   assign idx_next    = byte_idx_ff + {{(SIZE_W-1){1'b0}}, 1'b1};
   assign magic_bad   = (magic_cur > MW'(ipsp_pkg::MAGIC_LEN - 1))
                        || (in_byte_ff != ipsp_pkg::magic_byte(magic_cur));

   ipsp_region u_region (
      .cfg    (cfg),
      .offset (full_offset),
      .region (pick_region),
      .in_gap (pick_gap)
   );

   // Next state.
   always_comb begin
      phase_in      = phase_ff;
      magic_in      = magic_ff;
      rec_off_in    = rec_off_ff;
      rec_size_in   = rec_size_ff;
      byte_idx_in   = byte_idx_ff;
      rec_region_in = rec_region_ff;
      ovl_in        = ovl_ff;
      if (advance) begin
         phase_in = phase_cur;
         magic_in = magic_cur;
         ovl_in   = ovl_cur;
         case (phase_cur)
            ipsp_pkg::PH_MAGIC: begin
               if (magic_bad) begin
                  phase_in = ipsp_pkg::PH_BAD;
               end else begin
                  magic_in = magic_cur + {{(MW-1){1'b0}}, 1'b1};
                  if (magic_cur == MW'(ipsp_pkg::MAGIC_LEN - 1)) begin
                     phase_in = ipsp_pkg::PH_OFF0;
                  end
               end
            end
            ipsp_pkg::PH_OFF0: begin
               rec_off_in = {in_byte_ff, {(OFF_W-DW){1'b0}}};
               phase_in   = ipsp_pkg::PH_OFF1;
            end
            ipsp_pkg::PH_OFF1: begin
               rec_off_in = {rec_off_ff[OFF_W-1:2*DW], in_byte_ff, {DW{1'b0}}};
               phase_in   = ipsp_pkg::PH_OFF2;
            end
            ipsp_pkg::PH_OFF2: begin
               rec_off_in = full_offset;
               if (full_offset == ipsp_pkg::EOF_MARK) begin
                  phase_in = ipsp_pkg::PH_DONE;
               end else begin
                  ovl_in        = ovl_cur || pick_gap;
                  rec_region_in = pick_region;
                  phase_in      = ipsp_pkg::PH_SIZE0;
               end
            end
            ipsp_pkg::PH_SIZE0: begin
               rec_size_in = {in_byte_ff, {(SIZE_W-DW){1'b0}}};
               phase_in    = ipsp_pkg::PH_SIZE1;
            end
            ipsp_pkg::PH_SIZE1: begin
               rec_size_in = {rec_size_ff[SIZE_W-1:DW], in_byte_ff};
               byte_idx_in = '0;
               if ({rec_size_ff[SIZE_W-1:DW], in_byte_ff} == '0) begin
                  phase_in = ipsp_pkg::PH_RUN0;
               end else begin
                  phase_in = ipsp_pkg::PH_DATA;
               end
            end
            ipsp_pkg::PH_RUN0: begin
               rec_size_in = {in_byte_ff, {(SIZE_W-DW){1'b0}}};
               phase_in    = ipsp_pkg::PH_RUN1;
            end
            ipsp_pkg::PH_RUN1: begin
               rec_size_in = {rec_size_ff[SIZE_W-1:DW], in_byte_ff};
               phase_in    = ipsp_pkg::PH_RUNVAL;
            end
            ipsp_pkg::PH_RUNVAL: begin
               phase_in = ipsp_pkg::PH_OFF0;
            end
            ipsp_pkg::PH_DATA: begin
               byte_idx_in = idx_next;
               if (idx_next >= rec_size_ff) begin
                  phase_in = ipsp_pkg::PH_OFF0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result of the item in the input register.
   always_comb begin
      has_result = 1'b0;
      kind_in    = ipsp_pkg::KIND_WRITE;
      off_in     = '0;
      len_in     = '0;
      val_in     = '0;
      region_in  = ipsp_pkg::REGION_NONE;
      ovl_out_in = 1'b0;
      case (phase_cur)
         ipsp_pkg::PH_MAGIC: begin
            if (magic_bad) begin
               has_result = 1'b1;
               kind_in    = ipsp_pkg::KIND_BAD;
            end
         end
         ipsp_pkg::PH_OFF2: begin
            if (full_offset == ipsp_pkg::EOF_MARK) begin
               has_result = 1'b1;
               kind_in    = ipsp_pkg::KIND_DONE;
               ovl_out_in = ovl_cur;
            end
         end
         ipsp_pkg::PH_RUNVAL: begin
            has_result = 1'b1;
            kind_in    = ipsp_pkg::KIND_FILL;
            off_in     = rec_off_ff;
            len_in     = rec_size_ff;
            val_in     = in_byte_ff;
            region_in  = rec_region_ff;
         end
         ipsp_pkg::PH_DATA: begin
            has_result = 1'b1;
            kind_in    = ipsp_pkg::KIND_WRITE;
            off_in     = rec_off_ff + {{(OFF_W-SIZE_W){1'b0}}, byte_idx_ff};
            len_in     = {{(SIZE_W-1){1'b0}}, 1'b1};
            val_in     = in_byte_ff;
            region_in  = rec_region_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_valid && in_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = has_result;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= ipsp_pkg::PH_MAGIC;
         magic_ff     <= '0;
         ovl_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         magic_ff     <= magic_in;
         ovl_ff       <= ovl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_byte_ff  <= in_byte;
         in_first_ff <= in_first;
      end
      rec_off_ff    <= rec_off_in;
      rec_size_ff   <= rec_size_in;
      byte_idx_ff   <= byte_idx_in;
      rec_region_ff <= rec_region_in;
      if (advance && has_result) begin
         kind_ff    <= kind_in;
         off_ff     <= off_in;
         len_ff     <= len_in;
         val_ff     <= val_in;
         region_ff  <= region_in;
         ovl_out_ff <= ovl_out_in;
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_kind    = kind_ff;
   assign out_offset  = off_ff;
   assign out_length  = len_ff;
   assign out_value   = val_ff;
   assign out_region  = region_ff;
   assign out_overlay = ovl_out_ff;

endmodule
`default_nettype wire

// File: src/ips_patch_stream_parser_top.sv
// Top level of the IPS patch stream parser.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle while no waiting result is held back by rsp_tready,
// set by the single-pass parser between the input register and the result register.
// Reset: synchronous, active high; clears the parser, both handshakes and all
// configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module ips_patch_stream_parser_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ipsp_pkg::DATA_W-1:0]         req_tdata,  // patch_byte
   input  wire logic                                req_tuser,  // first_byte
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // target_offset, fill_length, data_value, target_region, overlay_touched, zero pad
   output logic [ipsp_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic [1:0]                               rsp_tuser,  // command_kind
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ipsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ipsp_pkg::CFG_W-1:0]          csr_data
);

   ipsp_pkg::cfg_type                  cfg;
   logic [ipsp_pkg::OFFSET_W-1:0]      out_offset;
   logic [ipsp_pkg::SIZE_W-1:0]        out_length;
   logic [ipsp_pkg::DATA_W-1:0]        out_value;
   logic [1:0]                         out_region;
   logic                               out_overlay;

   ipsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ipsp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .in_first    (req_tuser),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_offset  (out_offset),
      .out_length  (out_length),
      .out_value   (out_value),
      .out_region  (out_region),
      .out_overlay (out_overlay)
   );

   assign rsp_tdata = {5'b0, out_overlay, out_region, out_value, out_length, out_offset};

endmodule
`default_nettype wire

// File: src/ipsp_checker.sv
// Port-level assertions for the IPS patch stream parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module ipsp_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [ipsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic [1:0]                          rsp_tuser
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Done and bad-magic results carry only the overlay flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ipsp_pkg::KIND_DONE || rsp_tuser == ipsp_pkg::KIND_BAD)
      |-> rsp_tdata[49:0] == '0 && rsp_tdata[55:51] == '0)
      else $error("done or bad magic result has nonzero fields");

   // A byte write has length one and no overlay flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ipsp_pkg::KIND_WRITE
      |-> rsp_tdata[39:24] == 16'd1 && !rsp_tdata[50])
      else $error("byte write with bad length or flag");

   // No result is shown right after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind ips_patch_stream_parser_top ipsp_checker u_ipsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the IPS patch stream parser with its own prediction of every command.
`timescale 1ns / 1ps
module testbench;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD   = 400;
   localparam logic [39:0] PATCH_TAG   = 40'h5041544348;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } patch_byte_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] offset;
      logic [15:0] length;
      logic [7:0]  value;
      logic [1:0]  region;
      logic        touched;
   } patch_cmd_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   wire                                 req_tready;
   logic [ipsp_pkg::DATA_W-1:0]         req_tdata = '0;
   logic                                req_tuser = 1'b0;
   wire                                 rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   wire [ipsp_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   wire [1:0]                           rsp_tuser;
   logic                                csr_valid = 1'b0;
   wire                                 csr_ready;
   logic [ipsp_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [ipsp_pkg::CFG_W-1:0]          csr_data = '0;

   patch_byte_type byte_queue[$];
   patch_cmd_type  cmd_queue[$];
   int unsigned bytes_made = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned send_gap = 0;
   int unsigned hold_left = 0;
   logic        quiet = 1'b0;
   logic        stall_go = 1'b0;
   logic        stall_used = 1'b0;

   logic [31:0] cfg_a9s = '0, cfg_a9z = '0, cfg_a7s = '0, cfg_a7z = '0, cfg_ovs = '0;
   logic        cfg_only = 1'b0;

   ipsp_pkg::phase_type parse_ph;
   logic [2:0]  tag_idx;
   logic [23:0] rec_off;
   logic [15:0] rec_size;
   logic [15:0] byte_idx;
   logic [1:0]  rec_region;
   logic        gap_flag;

   ips_patch_stream_parser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [1:0] region_of(input logic [23:0] off);
      logic [32:0] a9e;
      logic [32:0] a7e;
      a9e = {1'b0, cfg_a9s} + {1'b0, cfg_a9z};
      a7e = {1'b0, cfg_a7s} + {1'b0, cfg_a7z};
      if (cfg_only || (off >= cfg_a9s && off < a9e)) return ipsp_pkg::REGION_ARM9;
      if (off >= cfg_a7s && off < a7e) return ipsp_pkg::REGION_ARM7;
      if (off >= cfg_ovs && off < cfg_a7s) return ipsp_pkg::REGION_OVERLAY;
      return ipsp_pkg::REGION_NONE;
   endfunction

   task automatic clear_parser();
      parse_ph   = ipsp_pkg::PH_MAGIC;
      tag_idx    = '0;
      rec_off    = '0;
      rec_size   = '0;
      byte_idx   = '0;
      rec_region = ipsp_pkg::REGION_NONE;
      gap_flag   = 1'b0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic first);
      patch_cmd_type cmd;
      logic          emit;
      logic [32:0]   a9e;
      cmd  = '0;
      emit = 1'b0;
      if (first) clear_parser();
      case (parse_ph)
         ipsp_pkg::PH_MAGIC: begin
            if (b != PATCH_TAG[39 - 8 * tag_idx -: 8]) begin
               parse_ph = ipsp_pkg::PH_BAD;
               cmd.kind = ipsp_pkg::KIND_BAD;
               emit = 1'b1;
            end else begin
               tag_idx = tag_idx + 3'd1;
               if (tag_idx == 3'(ipsp_pkg::MAGIC_LEN)) parse_ph = ipsp_pkg::PH_OFF0;
            end
         end
         ipsp_pkg::PH_OFF0: begin
            rec_off  = {b, 16'h0000};
            parse_ph = ipsp_pkg::PH_OFF1;
         end
         ipsp_pkg::PH_OFF1: begin
            rec_off[15:8] = b;
            parse_ph = ipsp_pkg::PH_OFF2;
         end
         ipsp_pkg::PH_OFF2: begin
            rec_off[7:0] = b;
            if (rec_off == ipsp_pkg::EOF_MARK) begin
               parse_ph    = ipsp_pkg::PH_DONE;
               cmd.kind    = ipsp_pkg::KIND_DONE;
               cmd.touched = gap_flag;
               emit = 1'b1;
            end else begin
               a9e = {1'b0, cfg_a9s} + {1'b0, cfg_a9z};
               if (rec_off >= a9e && rec_off < cfg_a7s) gap_flag = 1'b1;
               rec_region = region_of(rec_off);
               parse_ph = ipsp_pkg::PH_SIZE0;
            end
         end
         ipsp_pkg::PH_SIZE0: begin
            rec_size = {b, 8'h00};
            parse_ph = ipsp_pkg::PH_SIZE1;
         end
         ipsp_pkg::PH_SIZE1: begin
            rec_size[7:0] = b;
            byte_idx = '0;
            parse_ph = (rec_size == 16'd0) ? ipsp_pkg::PH_RUN0 : ipsp_pkg::PH_DATA;
         end
         ipsp_pkg::PH_RUN0: begin
            rec_size = {b, 8'h00};
            parse_ph = ipsp_pkg::PH_RUN1;
         end
         ipsp_pkg::PH_RUN1: begin
            rec_size[7:0] = b;
            parse_ph = ipsp_pkg::PH_RUNVAL;
         end
         ipsp_pkg::PH_RUNVAL: begin
            cmd.kind   = ipsp_pkg::KIND_FILL;
            cmd.offset = rec_off;
            cmd.length = rec_size;
            cmd.value  = b;
            cmd.region = rec_region;
            emit = 1'b1;
            parse_ph = ipsp_pkg::PH_OFF0;
         end
         ipsp_pkg::PH_DATA: begin
            cmd.kind   = ipsp_pkg::KIND_WRITE;
            cmd.offset = rec_off + {8'h00, byte_idx};
            cmd.length = 16'd1;
            cmd.value  = b;
            cmd.region = rec_region;
            emit = 1'b1;
            byte_idx = byte_idx + 16'd1;
            if (byte_idx >= rec_size) parse_ph = ipsp_pkg::PH_OFF0;
         end
         default: ;
      endcase
      if (emit) cmd_queue.push_back(cmd);
   endtask

   task automatic cmp_field(input string name, input logic [23:0] exp_v,
                            input logic [23:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   task automatic check_cmd(input logic [1:0] kind,
                            input logic [ipsp_pkg::RSP_DATA_W-1:0] data);
      patch_cmd_type exp_c;
      if (cmd_queue.size() == 0) begin
         $display("%0t: unexpected command expected none actual kind %0h data %0h",
                  $time, kind, data);
         errors++;
      end else begin
         exp_c = cmd_queue.pop_front();
         cmp_field("command_kind", 24'(exp_c.kind), 24'(kind));
         cmp_field("target_offset", exp_c.offset, data[23:0]);
         cmp_field("fill_length", 24'(exp_c.length), 24'(data[39:24]));
         cmp_field("data_value", 24'(exp_c.value), 24'(data[47:40]));
         cmp_field("target_region", 24'(exp_c.region), 24'(data[49:48]));
         cmp_field("overlay_touched", 24'(exp_c.touched), 24'(data[50]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
         clear_parser();
      end else begin
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tuser);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= byte_queue[0].data;
               req_tuser  <= byte_queue[0].first;
               void'(byte_queue.pop_front());
               send_gap <= idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         stall_used <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_cmd(rsp_tuser, rsp_tdata);
         if (stall_go && !stall_used) begin
            stall_used <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            hold_left <= idle_len();
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [ipsp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ipsp_pkg::CSR_ARM9_START:    cfg_a9s = value;
         ipsp_pkg::CSR_ARM9_SIZE:     cfg_a9z = value;
         ipsp_pkg::CSR_ARM7_START:    cfg_a7s = value;
         ipsp_pkg::CSR_ARM7_SIZE:     cfg_a7z = value;
         ipsp_pkg::CSR_OVERLAY_START: cfg_ovs = value;
         ipsp_pkg::CSR_ARM9_ONLY:     cfg_only = value[0];
         default: ;
      endcase
   endtask

   task automatic set_ranges(input logic [31:0] a9s, a9z, a7s, a7z, ovs, input logic only);
      csr_write(ipsp_pkg::CSR_ARM9_START, a9s);
      csr_write(ipsp_pkg::CSR_ARM9_SIZE, a9z);
      csr_write(ipsp_pkg::CSR_ARM7_START, a7s);
      csr_write(ipsp_pkg::CSR_ARM7_SIZE, a7z);
      csr_write(ipsp_pkg::CSR_OVERLAY_START, ovs);
      csr_write(ipsp_pkg::CSR_ARM9_ONLY, {31'b0, only});
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_tvalid || cmd_queue.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic put_byte(input logic [7:0] b, input logic first);
      patch_byte_type item;
      item.data  = b;
      item.first = first;
      byte_queue.push_back(item);
      bytes_made++;
   endtask

   task automatic put_magic();
      for (int i = 0; i < ipsp_pkg::MAGIC_LEN; i++)
         put_byte(PATCH_TAG[39 - 8 * i -: 8], i == 0);
   endtask

   task automatic put_offset(input logic [23:0] off);
      put_byte(off[23:16], 1'b0);
      put_byte(off[15:8], 1'b0);
      put_byte(off[7:0], 1'b0);
   endtask

   task automatic put_literal(input logic [23:0] off, input logic [15:0] size);
      put_offset(off);
      put_byte(size[15:8], 1'b0);
      put_byte(size[7:0], 1'b0);
      for (int i = 0; i < size; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic put_fill(input logic [23:0] off, input logic [15:0] count,
                           input logic [7:0] value);
      put_offset(off);
      put_byte(8'h00, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(count[15:8], 1'b0);
      put_byte(count[7:0], 1'b0);
      put_byte(value, 1'b0);
   endtask

   function automatic logic [23:0] pick_offset();
      logic [32:0] base;
      case ($urandom_range(0, 9))
         0, 1:    return 24'($urandom_range(0, 24'hFFFFFF));
         2:       return 24'hFFFFFF;
         3:       base = {1'b0, cfg_a9s};
         4:       base = {1'b0, cfg_a9s} + {1'b0, cfg_a9z};
         5:       base = {1'b0, cfg_a7s};
         6:       base = {1'b0, cfg_a7s} + {1'b0, cfg_a7z};
         7:       base = {1'b0, cfg_ovs};
         default: base = {1'b0, cfg_a9s} + {1'b0, $urandom_range(0, 24'hFFFF)};
      endcase
      base = base + {1'b0, $urandom_range(0, 4)} - 33'd2;
      return base[23:0];
   endfunction

   task automatic random_patch();
      int unsigned r;
      int unsigned n;
      logic [7:0]  b;
      logic [15:0] count;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         put_magic();
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 6) begin
               put_literal(pick_offset(), 16'($urandom_range(1, 6)));
            end else begin
               count = ($urandom_range(0, 4) == 0) ? 16'h0000
                                                   : 16'($urandom_range(0, 16'hFFFF));
               put_fill(pick_offset(), count, 8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 99) < 85) begin
            put_offset(ipsp_pkg::EOF_MARK);
            if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end else if (r < 90) begin
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) put_byte(PATCH_TAG[39 - 8 * i -: 8], i == 0);
         b = 8'($urandom_range(0, 255));
         if (b == PATCH_TAG[39 - 8 * n -: 8]) b = b ^ 8'h01;
         put_byte(b, n == 0);
         n = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned target;
      target = bytes_made + count;
      while (bytes_made < target) random_patch();
      wait_idle();
   endtask

   initial begin
      logic [31:0] a9s, a9z, a7s;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Zero configuration: offset wrap, empty and maximal fills, ignored tail,
      // a restart in the middle of a record and a broken magic.
      put_magic();
      put_byte(8'hFF, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'hFE, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'h03, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'hA5, 1'b0);
      put_fill(24'h000000, 16'h0000, 8'hFF);
      put_fill(24'hFFFFFF, 16'hFFFF, 8'h00);
      put_offset(ipsp_pkg::EOF_MARK);
      put_byte(8'h50, 1'b0);
      put_magic();
      put_byte(8'h12, 1'b0);
      put_magic();
      put_byte(8'h50, 1'b1);
      put_byte(8'h41, 1'b0);
      put_byte(8'h58, 1'b0);
      put_byte(8'h54, 1'b0);
      wait_idle();

      set_ranges(32'h0000_4000, 32'h000A_0000, 32'h0020_0000, 32'h0004_0000,
                 32'h0010_0000, 1'b0);
      random_phase(100);

      a9s = $urandom_range(0, 24'h3FFFFF);
      a9z = $urandom_range(0, 24'h1FFFFF);
      a7s = a9s + a9z + $urandom_range(0, 24'h1FFFFF);
      set_ranges(a9s, a9z, a7s, $urandom_range(0, 24'h3FFFFF),
                 a9s + a9z + $urandom_range(0, a7s - a9s - a9z), 1'b0);
      quiet = 1'b1;
      stall_go = 1'b1;
      random_phase(100);
      quiet = 1'b0;

      set_ranges(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h0080_0000, 1'b0);
      random_phase(90);

      set_ranges(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 1'b0);
      random_phase(90);

      set_ranges(32'h0000_4000, 32'h000A_0000, 32'h0020_0000, 32'h0004_0000,
                 32'h0010_0000, 1'b1);
      quiet = 1'b1;
      random_phase(90);
      quiet = 1'b0;

      set_ranges(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                 32'h0000_0000, 1'b0);
      random_phase(90);

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
